// ===== rtl/tun_pkg.sv =====
// Package for the triangle unit-normal pipeline: widths and shared types.
// Used by all modules under rtl; depends on nothing else.
package tun_pkg;

   localparam int CoordWidth = 16;
   localparam int EdgeWidth  = 17;
   localparam int CrossWidth = 34;
   localparam int MagWidth   = 33;
   localparam int SqWidth    = 66;
   localparam int SumWidth   = 68;
   localparam int AccWidth   = 102;   // (2q+1)^2 * sum stays below 2^100
   localparam int NormWidth  = 16;
   localparam int QBits      = 15;    // quotient 0..16384
   localparam int QMax       = 16384;

   // Result of the front end: squared magnitudes, signs, squared length.
   typedef struct packed {
      logic [2:0][SqWidth-1:0]  sq;
      logic [2:0]               neg;
      logic [SumWidth-1:0]      sum;
   } front_type;

endpackage

// ===== rtl/triangle_unit_normal_unit.sv =====
// Top level of the triangle unit-normal pipeline with output skid buffer.
// Depends on tun_pkg, tun_front and tun_div.
//
//  Channel | Direction | Payload
//  req_    | in        | tdata: a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z (144 bits)
//  rsp_    | out       | tdata: norm_x,norm_y,norm_z (48 bits); tuser: degenerate
//
// One triangle per cycle while the pipeline is not stalled; 5 front stages, 15 quotient
// stages and the output register make 21 register stages.
// Reset clears only valid bits. A stall freezes the whole pipeline once the skid
// slot is full; the skid register keeps the result in flight so none is lost.
module triangle_unit_normal_unit (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [143:0] req_tdata,  // a_x,a_y,a_z,b_x,b_y,b_z,c_x,c_y,c_z
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // norm_x, norm_y, norm_z
   output logic         rsp_tuser   // degenerate
);

   localparam int Q = tun_pkg::QBits;
   localparam int W = tun_pkg::AccWidth;

   logic                enable;
   logic                f_valid;
   tun_pkg::front_type  f_data;
   logic [Q-1:0]        v_ff;
   logic [2:0][Q:0][Q-1:0] q;
   logic [2:0][Q:0][W-1:0] p, l;
   tun_pkg::front_type  d_in [Q];
   tun_pkg::front_type  d_ff [Q];
   logic                out_valid_ff, skid_valid_ff;
   logic [48:0]         out_ff, skid_ff;
   logic [48:0]         res;

   // The pipeline advances whenever the skid slot is empty.
   assign enable     = !skid_valid_ff;
   assign req_tready = enable;

   tun_front u_front (
      .clock    (clock),
      .reset    (reset),
      .enable   (enable),
      .in_valid (req_tvalid),
      .coord    (req_tdata),
      .out_valid(f_valid),
      .out_data (f_data)
   );

   always_comb begin
      d_in[0] = f_data;
      for (int s = 1; s < Q; s++) d_in[s] = d_ff[s-1];
   end

   for (genvar c = 0; c < 3; c++) begin : g_comp
      assign q[c][0] = '0;
      assign p[c][0] = '0;
      assign l[c][0] = '0;
      for (genvar s = 0; s < Q; s++) begin : g_stage
         tun_div #(.Bit(Q-1-s)) u_div (
            .clock (clock),
            .enable(enable),
            .q_in  (q[c][s]),
            .p_in  (p[c][s]),
            .l_in  (l[c][s]),
            .sq    (d_in[s].sq[c]),
            .sum   (d_in[s].sum),
            .q_out (q[c][s+1]),
            .p_out (p[c][s+1]),
            .l_out (l[c][s+1])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int s = 0; s < Q; s++) d_ff[s] <= d_in[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (enable) begin
         v_ff <= {v_ff[Q-2:0], f_valid};
      end
   end

   always_comb begin
      logic degen;
      degen = (d_ff[Q-1].sum == '0);
      for (int c = 0; c < 3; c++) begin
         res[16*c +: 16] = degen ? 16'd0
            : (d_ff[Q-1].neg[c] ? 16'(-{1'b0, q[c][Q]}) : 16'({1'b0, q[c][Q]}));
      end
      res[48] = degen;
   end

   // Output register plus skid slot.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && !rsp_tready) begin
            if (enable && v_ff[Q-1]) begin
               skid_valid_ff <= 1'b1;
            end
         end else if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= v_ff[Q-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_valid_ff && !rsp_tready) begin
         if (enable) skid_ff <= res;
      end else if (skid_valid_ff) begin
         out_ff <= skid_ff;
      end else begin
         out_ff <= res;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff[47:0];
   assign rsp_tuser  = out_ff[48];

endmodule

// ===== rtl/tun_front.sv =====
// Front end: edge vectors, cross product, magnitudes, squares, squared length.
// Five register stages with a shared enable; depends on tun_pkg.
module tun_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [8:0][tun_pkg::CoordWidth-1:0] coord,
   output logic                         out_valid,
   output tun_pkg::front_type           out_data
);

   logic [4:0] valid_ff;

   // Stage 1: edges.
   logic signed [2:0][tun_pkg::EdgeWidth-1:0] e_ff, f_ff;
   // Stage 2: six products.
   logic signed [5:0][tun_pkg::CrossWidth-1:0] p_ff;
   logic [2:0][tun_pkg::CrossWidth-1:0] d;
   // Stage 3: cross product magnitudes and signs.
   logic [2:0][tun_pkg::MagWidth-1:0] m_ff;
   logic [2:0]                        n_ff;
   // Stage 4: squares; stage 5: squared length.
   logic [2:0][tun_pkg::SqWidth-1:0]  s_ff;
   logic [2:0]                        n2_ff;
   tun_pkg::front_type                out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         d[i] = p_ff[2*i] - p_ff[2*i+1];
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         for (int i = 0; i < 3; i++) begin
            e_ff[i] <= $signed({coord[3+i][15], coord[3+i]})
                     - $signed({coord[i][15], coord[i]});
            f_ff[i] <= $signed({coord[6+i][15], coord[6+i]})
                     - $signed({coord[i][15], coord[i]});
         end
         // Elements of a packed array read back unsigned, so the sign is restored here.
         p_ff[0] <= $signed(e_ff[1]) * $signed(f_ff[2]);
         p_ff[1] <= $signed(e_ff[2]) * $signed(f_ff[1]);
         p_ff[2] <= $signed(e_ff[2]) * $signed(f_ff[0]);
         p_ff[3] <= $signed(e_ff[0]) * $signed(f_ff[2]);
         p_ff[4] <= $signed(e_ff[0]) * $signed(f_ff[1]);
         p_ff[5] <= $signed(e_ff[1]) * $signed(f_ff[0]);
         for (int i = 0; i < 3; i++) begin
            n_ff[i] <= d[i][tun_pkg::CrossWidth-1];
            m_ff[i] <= d[i][tun_pkg::CrossWidth-1]
                     ? tun_pkg::MagWidth'(-d[i]) : tun_pkg::MagWidth'(d[i]);
         end
         for (int i = 0; i < 3; i++) begin
            s_ff[i] <= m_ff[i] * m_ff[i];
         end
         n2_ff      <= n_ff;
         out_ff.sq  <= s_ff;
         out_ff.neg <= n2_ff;
         out_ff.sum <= tun_pkg::SumWidth'(s_ff[0]) + tun_pkg::SumWidth'(s_ff[1])
                     + tun_pkg::SumWidth'(s_ff[2]);
      end
   end

   assign out_valid = valid_ff[4];
   assign out_data  = out_ff;

endmodule

// ===== rtl/tun_div.sv =====
// One restoring quotient-bit stage of the normalization search.
// Decides bit Bit of q for one component; depends on tun_pkg.
module tun_div #(
   parameter int Bit = 14
) (
   input  logic                          clock,
   input  logic                          enable,
   input  logic [tun_pkg::QBits-1:0]     q_in,
   input  logic [tun_pkg::AccWidth-1:0]  p_in,   // (2q)^2 * sum
   input  logic [tun_pkg::AccWidth-1:0]  l_in,   // 2q * sum
   input  logic [tun_pkg::SqWidth-1:0]   sq,
   input  logic [tun_pkg::SumWidth-1:0]  sum,
   output logic [tun_pkg::QBits-1:0]     q_out,
   output logic [tun_pkg::AccWidth-1:0]  p_out,
   output logic [tun_pkg::AccWidth-1:0]  l_out
);

   localparam int W = tun_pkg::AccWidth;

   // Test (2t-1)^2 * sum <= m^2 * 2^30 with t = q_in + d, d = 2^Bit. With w = 2q the
   // left side is P + 2(2d-1)L + (2d-1)^2 sum, so only shifts and adds are needed.
   logic [tun_pkg::QBits-1:0] trial;
   logic [W-1:0]              s_w, p_try, l_try, lhs, rhs;
   logic                      ok;

   always_comb begin
      trial = q_in | (tun_pkg::QBits'(1) << Bit);
      s_w   = W'(sum);
      p_try = p_in + (l_in << (Bit + 2)) + (s_w << (2 * Bit + 2));
      l_try = l_in + (s_w << (Bit + 1));
      lhs   = p_in + (l_in << (Bit + 2)) - (l_in << 1)
            + (s_w << (2 * Bit + 2)) - (s_w << (Bit + 2)) + s_w;
      rhs   = W'(sq) << 30;
      ok    = (trial <= tun_pkg::QBits'(tun_pkg::QMax)) && (lhs <= rhs);
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         if (ok) begin
            q_out <= trial;
            p_out <= p_try;
            l_out <= l_try;
         end else begin
            q_out <= q_in;
            p_out <= p_in;
            l_out <= l_in;
         end
      end
   end

endmodule

// ===== tb/sv/tb_triangle_unit_normal_checker.sv =====
// Scoreboard for the triangle unit-normal block: watches both stream channels,
// predicts each unit normal from the accepted triangle and compares field by field.
// Depends only on the channel signals handed in by tb_triangle_unit_normal_unit.
module tb_triangle_unit_normal_checker (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [143:0] req_tdata,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [47:0]  rsp_tdata,
   input  logic         rsp_tuser,
   output int           fail_count,
   output int           pending_normals
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [15:0] nz;
      logic [15:0] ny;
      logic [15:0] nx;
      logic        degen;
   } normal_type;

   normal_type expected_normals[$];

   // Largest q in 0..16384 with (2q-1)^2 * len2 <= mag^2 * 2^30, i.e. the
   // rounded quotient mag * 2^14 / sqrt(len2) with ties away from zero.
   function automatic logic [15:0] scaled_component(logic [33:0] mag, logic [127:0] len2);
      logic [127:0] bound;
      logic [127:0] lhs;
      longint       lo;
      longint       hi;
      longint       mid;
      bound = (128'(mag) * 128'(mag)) << 30;
      lo = 0;
      hi = 16384;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         lhs = 128'((2 * mid - 1) * (2 * mid - 1)) * len2;
         if (lhs <= bound) lo = mid;
         else hi = mid - 1;
      end
      return 16'(lo);
   endfunction

   function automatic normal_type face_normal(logic [143:0] vtx);
      logic signed [15:0] av, bv, cv;
      logic signed [16:0] e[3];
      logic signed [16:0] f[3];
      logic signed [33:0] n[3];
      logic [33:0]        mag[3];
      logic [127:0]       len2;
      logic [15:0]        q[3];
      normal_type         r;
      for (int i = 0; i < 3; i++) begin
         av = vtx[16*i +: 16];
         bv = vtx[48 + 16*i +: 16];
         cv = vtx[96 + 16*i +: 16];
         e[i] = {bv[15], bv} - {av[15], av};
         f[i] = {cv[15], cv} - {av[15], av};
      end
      n[0] = e[1] * f[2] - e[2] * f[1];
      n[1] = e[2] * f[0] - e[0] * f[2];
      n[2] = e[0] * f[1] - e[1] * f[0];
      len2 = '0;
      for (int i = 0; i < 3; i++) begin
         mag[i] = (n[i] < 0) ? -n[i] : n[i];
         len2 = len2 + 128'(mag[i]) * 128'(mag[i]);
      end
      if (len2 == 0) begin
         r = '{nz: '0, ny: '0, nx: '0, degen: 1'b1};
      end else begin
         for (int i = 0; i < 3; i++) begin
            q[i] = scaled_component(mag[i], len2);
            if (n[i] < 0) q[i] = -q[i];
         end
         r = '{nz: q[2], ny: q[1], nx: q[0], degen: 1'b0};
      end
      return r;
   endfunction

   always @(posedge clock) begin
      normal_type want;
      int         errs;
      errs = 0;
      if (reset) begin
         fail_count      <= 0;
         pending_normals <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_normals = {expected_normals, face_normal(req_tdata)};
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_normals.size() == 0) begin
               $error("unexpected response: tdata %h tuser %b", rsp_tdata, rsp_tuser);
               errs = errs + 1;
            end else begin
               want = expected_normals.pop_front();
               if (rsp_tdata[15:0] !== want.nx) begin
                  $error("norm_x: expected %0d, got %0d",
                         $signed(want.nx), $signed(rsp_tdata[15:0]));
                  errs = errs + 1;
               end
               if (rsp_tdata[31:16] !== want.ny) begin
                  $error("norm_y: expected %0d, got %0d",
                         $signed(want.ny), $signed(rsp_tdata[31:16]));
                  errs = errs + 1;
               end
               if (rsp_tdata[47:32] !== want.nz) begin
                  $error("norm_z: expected %0d, got %0d",
                         $signed(want.nz), $signed(rsp_tdata[47:32]));
                  errs = errs + 1;
               end
               if (rsp_tuser !== want.degen) begin
                  $error("degenerate: expected %b, got %b", want.degen, rsp_tuser);
                  errs = errs + 1;
               end
            end
         end
         fail_count      <= fail_count + errs;
         pending_normals <= expected_normals.size();
      end
   end

endmodule

// ===== tb/sv/tb_triangle_unit_normal_unit.sv =====
// Top of the triangle unit-normal testbench: clock, reset, triangle stimulus,
// response back-pressure and verdict. Depends on triangle_unit_normal_unit and the checker.
module tb_triangle_unit_normal_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RandomTriangles = 1700;
   localparam int IdleLimit       = 5000;
   localparam int SettleCycles    = 60;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [143:0] req_tdata;   // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [47:0]  rsp_tdata;   // norm_x, norm_y, norm_z
   logic         rsp_tuser;   // degenerate
   int           fail_count;
   int           pending_normals;
   int           idle_cycles;
   int           stall_left;
   bit           steady_sender;
   bit           steady_receiver;

   triangle_unit_normal_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   tb_triangle_unit_normal_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .rsp_tuser       (rsp_tuser),
      .fail_count      (fail_count),
      .pending_normals (pending_normals)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pause_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 50);
   endfunction

   // Back-pressure on the response side, with stall-free stretches now and then.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (steady_receiver) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_tready <= 1'b1;
         stall_left <= pause_length();
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   function automatic logic [143:0] pack_triangle(logic [15:0] v[9]);
      logic [143:0] d;
      for (int i = 0; i < 9; i++) d[16*i +: 16] = v[i];
      return d;
   endfunction

   task automatic send_triangle(logic [15:0] v[9]);
      int gap;
      gap = steady_sender ? 0 : pause_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pack_triangle(v);
      do @(posedge clock); while (!req_tready);
   endtask

   // A coordinate that is anywhere half the time, otherwise small or at a rail.
   function automatic logic [15:0] any_coord();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return 16'($urandom);
      if (r < 8) return 16'($signed($urandom_range(0, 1024)) - 512);
      return ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000;
   endfunction

   task automatic send_random();
      logic [15:0] v[9];
      logic signed [15:0] t;
      int kind;
      int pick;
      for (int i = 0; i < 9; i++) v[i] = any_coord();
      kind = $urandom_range(0, 19);
      if (kind == 0) begin
         // Two coincident vertices.
         pick = $urandom_range(0, 1);
         for (int i = 0; i < 3; i++) v[3 + 3 * pick + i] = v[i];
      end else if (kind == 1) begin
         // Collinear: the third vertex lies on the line through the first two, at b + k*(b - a), k in 0..3.
         for (int i = 0; i < 3; i++) begin
            v[i] = 16'($signed($urandom_range(0, 8000)) - 4000);
            v[3 + i] = 16'($signed($urandom_range(0, 8000)) - 4000);
            t = $signed(v[3 + i]) - $signed(v[i]);
            v[6 + i] = 16'($signed(v[3 + i]) + t * $signed(16'($urandom_range(0, 3))));
         end
      end else if (kind == 2) begin
         // Triangle in an axis-aligned plane of constant z.
         v[5] = v[2];
         v[8] = v[2];
      end
      send_triangle(v);
   endtask

   initial begin
      logic [15:0] v[9];
      int idx;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      steady_sender = 1'b1;
      steady_receiver = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed cases: all zero, right triangles of side 0x100 with a normal on each axis, rails, collinear.
      v = '{default: 16'h0000};
      send_triangle(v);
      v = '{16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
            16'h0000, 16'h0100, 16'h0000};
      send_triangle(v);
      v = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100, 16'h0000,
            16'h0000, 16'h0000, 16'h0100};
      send_triangle(v);
      v = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0100,
            16'h0100, 16'h0000, 16'h0000};
      send_triangle(v);
      v = '{16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h8000, 16'h8000,
            16'h8000, 16'h7FFF, 16'h8000};
      send_triangle(v);
      v = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF,
            16'h7FFF, 16'h8000, 16'h8000};
      send_triangle(v);
      v = '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
            16'h8000, 16'h8000, 16'h7FFF};
      send_triangle(v);
      v = '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF,
            16'h7FFF, 16'h7FFF, 16'h7FFF};
      send_triangle(v);
      v = '{16'h8000, 16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'h0000,
            16'h7FFF, 16'h7FFF, 16'h7FFF};
      send_triangle(v);
      v = '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0001, 16'h0001,
            16'h0002, 16'h0002, 16'h0002};
      send_triangle(v);
      v = '{16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h0000,
            16'h0000, 16'h0001, 16'h0001};
      send_triangle(v);
      v = '{16'hFFFF, 16'h0000, 16'h0001, 16'h0001, 16'hFFFF, 16'h0000,
            16'h0000, 16'h0001, 16'hFFFF};
      send_triangle(v);
      v = '{16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 16'h0FED, 16'hCBA9,
            16'h8765, 16'h4321, 16'hAAAA};
      send_triangle(v);

      // The sender holds off until every outstanding normal has come back.
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_normals != 0) @(posedge clock);

      steady_sender = 1'b0;
      for (idx = 0; idx < RandomTriangles; idx++) begin
         if (idx % 250 == 0) begin
            steady_sender = ($urandom_range(0, 3) == 0);
            steady_receiver = ($urandom_range(0, 3) == 0);
         end
         send_random();
      end
      req_tvalid <= 1'b0;
      steady_receiver = 1'b0;

      @(posedge clock);
      while (pending_normals != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
      if (fail_count == 0 && pending_normals == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/tun_pkg.sv
rtl/tun_front.sv
rtl/tun_div.sv
rtl/triangle_unit_normal_unit.sv
tb/sv/tb_triangle_unit_normal_checker.sv
tb/sv/tb_triangle_unit_normal_unit.sv
